### rtl/core/prdt_pkg.sv
// Shared types and constants for the prescaled reload down timer.
// Holds the bus mode codes, control bit positions, register indexes and the result type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package prdt_pkg;

    // Field widths fixed by the bus interface.
    localparam int ModeBits     = 2;
    localparam int DataBits     = 16;
    localparam int PrescaleBits = 8;
    localparam int DivSelBits   = 3;
    localparam int DivCountBits = 5;
    localparam int CfgIndexBits = 2;

    typedef logic [ModeBits-1:0]     mode_t;
    typedef logic [DataBits-1:0]     data_t;
    typedef logic [PrescaleBits-1:0] prescale_t;
    typedef logic [DivSelBits-1:0]   div_sel_t;
    typedef logic [DivCountBits-1:0] div_count_t;
    typedef logic [CfgIndexBits-1:0] cfg_index_t;

    // Transaction modes on the input channel.
    localparam mode_t MODE_TICK      = 2'd0;
    localparam mode_t MODE_WR_CTRL   = 2'd1;
    localparam mode_t MODE_WR_BUFFER = 2'd2;
    localparam mode_t MODE_RD_COUNT  = 2'd3;

    // Control word bit positions.
    localparam int CTRL_START_BIT  = 0;
    localparam int CTRL_LOAD_BIT   = 1;
    localparam int CTRL_RELOAD_BIT = 3;

    // Configuration register indexes.
    localparam cfg_index_t REG_PRESCALE = 2'd0;
    localparam cfg_index_t REG_DIV_SEL  = 2'd1;

    // Largest divider select honored; anything above divides by 32.
    localparam div_sel_t DIV_SEL_MAX = 3'd4;

    // One result transaction.
    typedef struct packed {
        data_t read_data;
        logic  irq;
        logic  running;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/prescaled_reload_down_timer.sv
// Prescaled reload down timer: one timer channel with prescaler, divider and down counter.
// A two-entry output stage decouples the result channel from the input channel.
// Depends on prdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one transaction per clock cycle while its skid register is empty and
// answers each with exactly one result transaction, registered in the output register or,
// while the consumer stalls, in the skid register. A transaction is a clock tick (mode 0),
// a control write (mode 1), a count buffer write (mode 2) or a count read (mode 3). Ticks
// only advance the prescaler and divider while the timer runs; each divider wrap
// decrements the count, and reaching zero raises irq in that tick's result and either
// reloads from the buffer or stops the timer. All state updates for a transaction happen
// in the cycle it is accepted, so throughput is one transaction per cycle while the skid
// register is empty; the skid register lets s_ready stay high for one more transaction
// when the consumer stalls. Configuration writes (index 0 prescale, index 1 divider
// select) are ready whenever the block is out of reset and should be issued only while
// no result is pending. Both ready outputs are low while aresetn is asserted.
module prescaled_reload_down_timer #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Input channel
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire prdt_pkg::mode_t         s_mode,
    input  wire prdt_pkg::data_t         s_write_data,
    // Result channel
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output prdt_pkg::data_t              m_read_data,
    output logic                         m_irq,
    output logic                         m_running,
    // Configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire prdt_pkg::cfg_index_t    cfg_index,
    input  wire prdt_pkg::prescale_t     cfg_data
);
    import prdt_pkg::*;

    localparam int WideBits = (COUNT_BITS > DataBits) ? COUNT_BITS : DataBits;

    // Configuration registers.
    prescale_t               prescale_reg;
    div_sel_t                div_sel_reg;

    // Timer state.
    prescale_t               ps_count_reg,   ps_count_next;
    div_count_t              div_count_reg,  div_count_next;
    logic [COUNT_BITS-1:0]   down_count_reg, down_count_next;
    logic [COUNT_BITS-1:0]   buffer_reg,     buffer_next;
    logic                    run_reg,        run_next;
    logic                    reload_reg,     reload_next;

    // Output stage.
    logic                    out_valid_reg;
    result_t                 out_reg;
    logic                    skid_valid_reg;
    result_t                 skid_reg;

    logic                    s_accept;
    logic                    out_free;
    result_t                 result;

    logic [WideBits-1:0]     data_wide;
    logic [WideBits-1:0]     count_wide;
    div_sel_t                sel_clamped;
    div_count_t              div_limit;
    logic                    ps_wrap;
    logic                    timer_tick;
    logic [COUNT_BITS-1:0]   count_dec;

    assign cfg_ready = aresetn;
    assign s_ready   = aresetn && !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;

    assign m_valid     = out_valid_reg;
    assign m_read_data = out_reg.read_data;
    assign m_irq       = out_reg.irq;
    assign m_running   = out_reg.running;

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            div_sel_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PRESCALE: prescale_reg <= cfg_data;
                REG_DIV_SEL:  div_sel_reg  <= cfg_data[DivSelBits-1:0];
                default:      ;
            endcase
        end
    end

    // Divider terminal count: 2^(select+1) - 1 with the select clamped to four.
    always_comb begin
        sel_clamped = (div_sel_reg > DIV_SEL_MAX) ? DIV_SEL_MAX : div_sel_reg;
        div_limit   = div_count_t'((6'd2 << sel_clamped) - 6'd1);
    end

    // Width adaptation between the 16-bit bus and the counter width.
    assign data_wide  = WideBits'(s_write_data);
    assign count_wide = WideBits'(down_count_reg);

    // Next state and result for the transaction on the input channel.
    always_comb begin
        ps_count_next   = ps_count_reg;
        div_count_next  = div_count_reg;
        down_count_next = down_count_reg;
        buffer_next     = buffer_reg;
        run_next        = run_reg;
        reload_next     = reload_reg;
        result          = '0;

        ps_wrap    = ps_count_reg >= prescale_reg;
        timer_tick = 1'b0;
        count_dec  = (down_count_reg != '0) ? down_count_reg - 1'b1 : '0;

        case (s_mode)
            MODE_TICK: begin
                if (run_reg) begin
                    if (ps_wrap) begin
                        ps_count_next = '0;
                        if (div_count_reg >= div_limit) begin
                            div_count_next = '0;
                            timer_tick     = 1'b1;
                        end else begin
                            div_count_next = div_count_reg + 1'b1;
                        end
                    end else begin
                        ps_count_next = ps_count_reg + 1'b1;
                    end
                end
                // A tick that leaves the count at zero is an expiry.
                if (timer_tick) begin
                    down_count_next = count_dec;
                    if (count_dec == '0) begin
                        result.irq = 1'b1;
                        if (reload_reg) begin
                            down_count_next = buffer_reg;
                        end else begin
                            run_next = 1'b0;
                        end
                    end
                end
            end
            MODE_WR_CTRL: begin
                reload_next = s_write_data[CTRL_RELOAD_BIT];
                if (s_write_data[CTRL_LOAD_BIT]) begin
                    down_count_next = buffer_reg;
                end
                run_next = s_write_data[CTRL_START_BIT];
            end
            MODE_WR_BUFFER: begin
                buffer_next = data_wide[COUNT_BITS-1:0];
            end
            default: begin
                result.read_data = count_wide[DataBits-1:0];
            end
        endcase

        result.running = run_next;
    end

    // Timer state update on each accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_count_reg   <= '0;
            div_count_reg  <= '0;
            down_count_reg <= '0;
            buffer_reg     <= '0;
            run_reg        <= 1'b0;
            reload_reg     <= 1'b0;
        end else if (s_accept) begin
            ps_count_reg   <= ps_count_next;
            div_count_reg  <= div_count_next;
            down_count_reg <= down_count_next;
            buffer_reg     <= buffer_next;
            run_reg        <= run_next;
            reload_reg     <= reload_next;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (s_accept) begin
            // The skid register is empty whenever a transaction is accepted.
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (out_free) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end else if (out_free && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for the prescaled reload down timer.
// Drives input and result channels with random gaps, writes the register channel and checks every result.
// Depends on prdt_pkg and prescaled_reload_down_timer.
`timescale 1ns / 1ps

module tb_top;
    import prdt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 115;
    localparam int NUM_ROWS    = 27;

    // One row of the directed table; typed rows carry their expected result.
    typedef struct packed {
        mode_t   mode;
        data_t   data;
        logic    typed;
        result_t res;
    } stim_row_t;

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    mode_t      s_mode       = MODE_TICK;
    data_t      s_write_data = '0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    data_t      m_read_data;
    logic       m_irq;
    logic       m_running;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index    = REG_PRESCALE;
    prescale_t  cfg_data     = '0;

    // Timer state as the bench expects it to be.
    prescale_t  prescale_q  = '0;
    div_sel_t   div_sel_q   = '0;
    prescale_t  presc_cnt_q = '0;
    div_count_t div_cnt_q   = '0;
    data_t      count_q     = '0;
    data_t      buffer_q    = '0;
    logic       run_q       = 1'b0;
    logic       reload_q    = 1'b0;

    result_t    expected_q[$];
    result_t    oldest_res;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         errors         = 0;
    int         items_sent     = 0;
    int         results_seen   = 0;
    int         irq_count      = 0;
    int         reg_writes     = 0;
    int         cycle_count    = 0;

    prescale_t  presc_set [NUM_PHASES] = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd0, 8'd7, 8'd0, 8'd3};
    div_sel_t   sel_set   [NUM_PHASES] = '{3'd0, 3'd7, 3'd4, 3'd1, 3'd5, 3'd2, 3'd0, 3'd3};

    // Directed table: reset values, an all-ones buffer, load and start, reload and one-shot
    // expiry, and an expiry on a tick that finds the count already at zero.
    stim_row_t  directed_rows [NUM_ROWS] = '{
        '{MODE_RD_COUNT,  16'ha5a5, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{MODE_TICK,      16'hffff, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{MODE_WR_BUFFER, 16'hffff, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{MODE_WR_CTRL,   16'h0002, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{MODE_RD_COUNT,  16'h0000, 1'b1, '{16'hffff, 1'b0, 1'b0}},
        '{MODE_WR_BUFFER, 16'h0003, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{MODE_WR_CTRL,   16'hffff, 1'b1, '{16'h0000, 1'b0, 1'b1}},
        '{MODE_RD_COUNT,  16'h0000, 1'b1, '{16'h0003, 1'b0, 1'b1}},
        '{MODE_TICK,      16'h0000, 1'b0, '0},
        '{MODE_TICK,      16'hffff, 1'b0, '0},
        '{MODE_TICK,      16'h0000, 1'b0, '0},
        '{MODE_TICK,      16'hffff, 1'b0, '0},
        '{MODE_TICK,      16'h0000, 1'b0, '0},
        '{MODE_TICK,      16'hffff, 1'b0, '0},
        '{MODE_RD_COUNT,  16'hffff, 1'b0, '0},
        '{MODE_WR_CTRL,   16'hfff1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
        '{MODE_TICK,      16'h5555, 1'b0, '0},
        '{MODE_TICK,      16'haaaa, 1'b0, '0},
        '{MODE_TICK,      16'h5555, 1'b0, '0},
        '{MODE_TICK,      16'haaaa, 1'b0, '0},
        '{MODE_TICK,      16'h5555, 1'b0, '0},
        '{MODE_TICK,      16'haaaa, 1'b0, '0},
        '{MODE_RD_COUNT,  16'h0000, 1'b0, '0},
        '{MODE_WR_CTRL,   16'h0001, 1'b1, '{16'h0000, 1'b0, 1'b1}},
        '{MODE_TICK,      16'h0000, 1'b0, '0},
        '{MODE_TICK,      16'h0000, 1'b0, '0},
        '{MODE_WR_CTRL,   16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}}
    };

    prescaled_reload_down_timer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq        (m_irq),
        .m_running    (m_running),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Advance the expected timer state by one transaction and return its result.
    function automatic result_t predict_timer(mode_t mode, data_t data);
        result_t    res;
        div_sel_t   sel;
        div_count_t limit;
        logic       tick;
        res = '0;
        case (mode)
            MODE_TICK: begin
                if (run_q) begin
                    sel   = (div_sel_q > DIV_SEL_MAX) ? DIV_SEL_MAX : div_sel_q;
                    limit = div_count_t'((1 << (sel + 1)) - 1);
                    tick  = 1'b0;
                    // The prescaler and divider wrap when at or above their limit.
                    if (presc_cnt_q < prescale_q) begin
                        presc_cnt_q = presc_cnt_q + 1'b1;
                    end else begin
                        presc_cnt_q = '0;
                        if (div_cnt_q >= limit) begin
                            div_cnt_q = '0;
                            tick      = 1'b1;
                        end else begin
                            div_cnt_q = div_cnt_q + 1'b1;
                        end
                    end
                    // A tick that leaves the count at zero expires, even from zero.
                    if (tick) begin
                        if (count_q != '0) begin
                            count_q = count_q - 1'b1;
                        end
                        if (count_q == '0) begin
                            res.irq = 1'b1;
                            if (reload_q) begin
                                count_q = buffer_q;
                            end else begin
                                run_q = 1'b0;
                            end
                        end
                    end
                end
            end
            MODE_WR_CTRL: begin
                reload_q = data[CTRL_RELOAD_BIT];
                if (data[CTRL_LOAD_BIT]) begin
                    count_q = buffer_q;
                end
                run_q = data[CTRL_START_BIT];
            end
            MODE_WR_BUFFER: begin
                buffer_q = data;
            end
            default: begin
                res.read_data = count_q;
            end
        endcase
        res.running = run_q;
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        errors++;
        $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, results_seen, got, want);
    endtask

    // Offer one input transaction, with an optional idle gap before it.
    task automatic push_item(mode_t mode, data_t data, logic typed, result_t typed_res);
        result_t res;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        res = predict_timer(mode, data);
        expected_q.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    task automatic write_register(cfg_index_t index, prescale_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_PRESCALE: prescale_q = value;
            REG_DIV_SEL:  div_sel_q  = value[DivSelBits-1:0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Check each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", m_read_data, 0);
            end else begin
                oldest_res = expected_q.pop_front();
                if (m_read_data !== oldest_res.read_data) begin
                    report_mismatch("read_data", m_read_data, oldest_res.read_data);
                end
                if (m_irq !== oldest_res.irq) begin
                    report_mismatch("irq", m_irq, oldest_res.irq);
                end
                if (m_running !== oldest_res.running) begin
                    report_mismatch("running", m_running, oldest_res.running);
                end
                if (m_irq === 1'b1) begin
                    irq_count++;
                end
            end
            results_seen++;
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Stimulus: directed table, then random phases under different settings.
    initial begin
        int  phase_start;
        int  kind;
        int  burst;
        logic mid_drained;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            push_item(directed_rows[i].mode, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].res);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            write_register(cfg_index_t'(2 + $urandom_range(1)), prescale_t'($urandom));
            write_register(REG_PRESCALE, presc_set[ph]);
            write_register(REG_DIV_SEL,
                           prescale_t'(($urandom_range(31) << DivSelBits) | sel_set[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            phase_start = items_sent;
            mid_drained = 1'b0;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                // Halfway through, hold off until all results are back.
                if (!mid_drained && items_sent - phase_start >= PHASE_ITEMS / 2) begin
                    drain_results();
                    mid_drained = 1'b1;
                end
                kind = $urandom_range(9);
                if (kind <= 6) begin
                    // Load a mostly small buffer, start, then run ticks with some reads.
                    burst = $urandom_range(30, 4);
                    push_item(MODE_WR_BUFFER, ($urandom_range(3) == 0) ?
                              data_t'($urandom) : data_t'($urandom_range(12)), 1'b0, '0);
                    push_item(MODE_WR_CTRL, data_t'($urandom) | data_t'(3), 1'b0, '0);
                    repeat (burst) begin
                        push_item(($urandom_range(5) == 0) ? MODE_RD_COUNT : MODE_TICK,
                                  data_t'($urandom), 1'b0, '0);
                    end
                end else if (kind == 7) begin
                    push_item(MODE_WR_CTRL, data_t'($urandom), 1'b0, '0);
                end else begin
                    repeat (4) begin
                        push_item(mode_t'($urandom_range(3)), data_t'($urandom), 1'b0, '0);
                    end
                end
            end
        end

        send_idle_pct = 0;
        drain_results();
        repeat (8) @(posedge aclk);

        $display("Sent %0d transactions over %0d register settings and %0d register writes.",
                 items_sent, NUM_PHASES, reg_writes);
        $display("Checked %0d results, %0d with irq set; %0d mismatches.",
                 results_seen, irq_count, errors);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
